// ===== hw/rtl/wprs_pkg.sv =====
`default_nettype none

package wprs_pkg;

    // Field widths of the request and result items.
    localparam int VALUE_W    = 32;
    localparam int GROUP_W    = 2;
    localparam int WEIGHT_W   = 32;
    localparam int RANK_W     = 34;
    localparam int COUNT_W    = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Default sizing of the block.
    localparam int WPRS_MAX_SAMPLES = 65536;
    localparam int WPRS_NUM_GROUPS  = 4;

    // Fixed-point constants in Q16.16 units.
    localparam logic [RANK_W-1:0]   SUM_MAX      = {RANK_W{1'b1}};
    localparam logic [RANK_W-1:0]   ONE_Q16      = RANK_W'(65536);
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(65536);
    localparam int                  COUNT_LIMIT  = (1 << COUNT_W) - 1;

    // Rank modes; the unused code answers as mid.
    typedef enum logic [1:0] {
        MODE_MID = 2'd0,
        MODE_MIN = 2'd1,
        MODE_MAX = 2'd2
    } rank_mode_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANK_MODE = 3'd0,
        REG_WEIGHT_G0 = 3'd1,
        REG_WEIGHT_G1 = 3'd2,
        REG_WEIGHT_G2 = 3'd3,
        REG_WEIGHT_G3 = 3'd4
    } cfg_reg_t;

    // One sorted sample.
    typedef struct packed {
        logic [VALUE_W-1:0] sample_value;
        logic [GROUP_W-1:0] group_index;
        logic               end_of_data;
    } wprs_in_t;

    // One closed run.
    typedef struct packed {
        logic [RANK_W-1:0]  rank_value;
        logic [COUNT_W-1:0] run_length;
        logic               final_result;
    } wprs_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/weighted_pseudo_rank_stream.sv =====
`default_nettype none

// An accepted request is held in the input register until the result buffer has room for
// all its results, then processed into it; its first result is shown on m_data from the head.
// Throughput: one request per cycle while the two-entry result buffer has room; one that
// closes a run and ends the data set yields two results, one per cycle while m_ready is high.
// Reset (aresetn low, synchronous) clears all run state and the result buffer, sets the
// rank mode to mid and every group weight to 1.0.
module weighted_pseudo_rank_stream #(
    parameter int MAX_SAMPLES = wprs_pkg::WPRS_MAX_SAMPLES,
    parameter int NUM_GROUPS  = wprs_pkg::WPRS_NUM_GROUPS
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire wprs_pkg::wprs_in_t                  s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output wprs_pkg::wprs_out_t                      m_data,
    input  wire logic                                cfg_we,
    input  wire logic [wprs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [wprs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import wprs_pkg::*;

    localparam int CountCapInt = (MAX_SAMPLES < COUNT_LIMIT) ? MAX_SAMPLES : COUNT_LIMIT;
    localparam logic [COUNT_W-1:0] CountCap = COUNT_W'(CountCapInt);

    // Saturating add of two weight sums.
    function automatic logic [RANK_W-1:0] sat_add(input logic [RANK_W-1:0] a,
                                                   input logic [RANK_W-1:0] b);
        logic [RANK_W:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[RANK_W] ? SUM_MAX : t[RANK_W-1:0];
    endfunction

    // Shared rank of a run from the sum before it and its own weight.
    function automatic logic [RANK_W-1:0] run_rank(input logic [1:0]        mode,
                                                    input logic [RANK_W-1:0] s,
                                                    input logic [RANK_W-1:0] r);
        logic [RANK_W+1:0] t;
        unique case (mode)
            MODE_MIN: t = {2'b00, s} + {2'b00, ONE_Q16};
            MODE_MAX: t = {2'b00, s} + {2'b00, r};
            default:  t = ({2'b00, ONE_Q16} + {1'b0, s, 1'b0} + {2'b00, r}) >> 1;
        endcase
        return (t > {2'b00, SUM_MAX}) ? SUM_MAX : t[RANK_W-1:0];
    endfunction

    // Configuration registers.
    logic [1:0]          mode_reg;
    logic [WEIGHT_W-1:0] weight_reg [NUM_GROUPS];

    // Input register.
    logic     in_valid_reg;
    wprs_in_t in_data_reg;

    // Run state.
    logic [RANK_W-1:0]  sum_reg;
    logic [RANK_W-1:0]  run_wt_reg;
    logic [COUNT_W-1:0] run_cnt_reg;
    logic [VALUE_W-1:0] run_val_reg;
    logic               run_open_reg;

    // Two-entry result buffer, buf0 is the head.
    wprs_out_t buf0_reg, buf1_reg;
    logic [1:0] cnt_reg;

    logic [WEIGHT_W-1:0] grp_weight;
    logic                same_run, closing;
    logic [RANK_W-1:0]   sum_new, wt_new;
    logic [COUNT_W-1:0]  cnt_new;
    logic [1:0]          nres, push_n, cnt_pop;
    logic                pop, proc_fire;
    wprs_out_t           res0, res1, buf0_next, buf1_next;

    // Group weight lookup; groups beyond the configured count weigh nothing.
    always_comb begin
        grp_weight = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            if (in_data_reg.group_index == GROUP_W'(g)) begin
                grp_weight = weight_reg[g];
            end
        end
    end

    // Next run state and the results this sample produces.
    always_comb begin
        same_run = run_open_reg && (in_data_reg.sample_value == run_val_reg);
        closing  = run_open_reg && !same_run;
        sum_new  = closing ? sat_add(sum_reg, run_wt_reg) : sum_reg;
        if (same_run) begin
            wt_new  = sat_add(run_wt_reg, {2'b00, grp_weight});
            cnt_new = (run_cnt_reg < CountCap) ? run_cnt_reg + 1'b1 : run_cnt_reg;
        end else begin
            wt_new  = {2'b00, grp_weight};
            cnt_new = COUNT_W'(1);
        end
        nres = {1'b0, closing} + {1'b0, in_data_reg.end_of_data};

        res1.rank_value   = run_rank(mode_reg, sum_new, wt_new);
        res1.run_length   = cnt_new;
        res1.final_result = 1'b1;
        if (closing) begin
            res0.rank_value   = run_rank(mode_reg, sum_reg, run_wt_reg);
            res0.run_length   = run_cnt_reg;
            res0.final_result = 1'b0;
        end else begin
            res0 = res1;
        end
    end

    // Handshake: process only when the buffer has room for every result.
    always_comb begin
        m_valid   = (cnt_reg != 2'd0);
        m_data    = buf0_reg;
        pop       = m_valid && m_ready;
        cnt_pop   = cnt_reg - {1'b0, pop};
        proc_fire = in_valid_reg && (({1'b0, cnt_pop} + {1'b0, nres}) <= 3'd2);
        s_ready   = !in_valid_reg || proc_fire;
        push_n    = proc_fire ? nres : 2'd0;
    end

    // Result buffer: shift on a pop, then append behind the remaining entries.
    always_comb begin
        buf0_next = pop ? buf1_reg : buf0_reg;
        buf1_next = buf1_reg;
        if (push_n != 2'd0) begin
            if (cnt_pop == 2'd0) begin
                buf0_next = res0;
                if (push_n == 2'd2) begin
                    buf1_next = res1;
                end
            end else begin
                buf1_next = res0;
            end
        end
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_MID;
            for (int g = 0; g < NUM_GROUPS; g++) begin
                weight_reg[g] <= WEIGHT_RESET;
            end
        end else if (cfg_we) begin
            if (cfg_index == REG_RANK_MODE) begin
                mode_reg <= cfg_wdata[1:0];
            end
            for (int g = 0; g < NUM_GROUPS; g++) begin
                if (cfg_index == CFG_IDX_W'(int'(REG_WEIGHT_G0) + g)) begin
                    weight_reg[g] <= cfg_wdata[WEIGHT_W-1:0];
                end
            end
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // Run state update; the end of the data set returns it to reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg      <= '0;
            run_wt_reg   <= '0;
            run_cnt_reg  <= '0;
            run_val_reg  <= '0;
            run_open_reg <= 1'b0;
        end else if (proc_fire) begin
            if (in_data_reg.end_of_data) begin
                sum_reg      <= '0;
                run_wt_reg   <= '0;
                run_cnt_reg  <= '0;
                run_val_reg  <= '0;
                run_open_reg <= 1'b0;
            end else begin
                sum_reg      <= sum_new;
                run_wt_reg   <= wt_new;
                run_cnt_reg  <= cnt_new;
                run_val_reg  <= in_data_reg.sample_value;
                run_open_reg <= 1'b1;
            end
        end
    end

    // Result buffer registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_pop + push_n;
        end
    end

    always_ff @(posedge aclk) begin
        buf0_reg <= buf0_next;
        buf1_reg <= buf1_next;
    end

`ifndef SYNTHESIS
    // The result buffer never holds more than its two entries.
    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg <= 2'd2)
        else $error("result buffer overfilled");

    // A run is open exactly when its sample count is nonzero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        run_open_reg == (run_cnt_reg != '0))
        else $error("run open flag and run count disagree");

    // Processing the last sample closes every run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire && in_data_reg.end_of_data |=> !run_open_reg && sum_reg == '0)
        else $error("state not cleared after end of data");

    // A sample that ends the data set always leaves a final result behind.
    assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire && in_data_reg.end_of_data |=> m_valid)
        else $error("no result after end of data");
`endif

endmodule

`default_nettype wire
